>>> hdl/pep_pkg.sv
// Shared types and constants for the polynomial evaluator with range maximum.
package pep_pkg;

	localparam int NUM_COEFF   = 7;
	localparam int COEFF_W     = 16;
	localparam int X_W         = 8;
	localparam int VALUE_W     = 64;
	localparam int TERM_W      = 3;
	localparam int APB_DATA_W  = 32;
	localparam int APB_ADDR_W  = 5;
	localparam int REG_IDX_W   = 3;

	localparam logic [REG_IDX_W-1:0] REG_TERM_COUNT = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_COEFF_0    = 3'd1;

	typedef logic signed [COEFF_W-1:0] coeff_t;
	typedef logic [NUM_COEFF-1:0][COEFF_W-1:0] coeff_arr_t;

	typedef struct packed {
		logic load;
		logic step;
		logic check;
		logic advance;
		logic store;
	} pep_cmd_t;

	typedef struct packed {
		logic last_term;
		logic range_empty;
		logic at_end;
		logic is_max;
		logic out_free;
	} pep_sts_t;

endpackage

>>> hdl/pep_req_if.sv
// Request channel: request type and the x range.
interface pep_req_if;
	logic                            valid;
	logic                            ready;
	logic                            req_type;
	logic signed [pep_pkg::X_W-1:0]  x_low;
	logic signed [pep_pkg::X_W-1:0]  x_high;

	modport source (output valid, req_type, x_low, x_high, input ready);
	modport sink   (input valid, req_type, x_low, x_high, output ready);
endinterface

>>> hdl/pep_res_if.sv
// Result channel: polynomial value or range maximum with its clip flag.
interface pep_res_if;
	logic                                valid;
	logic                                ready;
	logic signed [pep_pkg::VALUE_W-1:0]  value;
	logic                                saturated;

	modport source (output valid, value, saturated, input ready);
	modport sink   (input valid, value, saturated, output ready);
endinterface

>>> hdl/pep_regs.sv
// APB register file: term count and the seven Q8.8 coefficients.
module pep_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [pep_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [pep_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [pep_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                pready,
	output logic [pep_pkg::TERM_W-1:0]          term_count,
	output pep_pkg::coeff_arr_t                 coeff
);

	logic [pep_pkg::TERM_W-1:0]      term_count_q;
	pep_pkg::coeff_arr_t             coeff_q;
	logic [pep_pkg::REG_IDX_W-1:0]   idx;
	logic [pep_pkg::REG_IDX_W-1:0]   cidx;
	logic                            wr_en;

	assign idx    = paddr[pep_pkg::APB_ADDR_W-1:2];
	assign cidx   = idx - pep_pkg::REG_COEFF_0;
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_count_q <= 3'd1;
			coeff_q      <= '0;
		end else if (wr_en) begin
			if (idx == pep_pkg::REG_TERM_COUNT) begin
				term_count_q <= pwdata[pep_pkg::TERM_W-1:0];
			end else begin
				coeff_q[cidx] <= pwdata[pep_pkg::COEFF_W-1:0];
			end
		end
	end

	always_comb begin
		if (idx == pep_pkg::REG_TERM_COUNT) begin
			prdata = {29'd0, term_count_q};
		end else begin
			prdata = {{16{coeff_q[cidx][pep_pkg::COEFF_W-1]}}, coeff_q[cidx]};
		end
	end

	assign term_count = term_count_q;
	assign coeff      = coeff_q;

endmodule

>>> hdl/pep_ctrl.sv
// Sequencer: walks Horner steps per point and points per range.
module pep_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  pep_pkg::pep_sts_t  sts,
	output pep_pkg::pep_cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_EVAL  = 4'b0010,
		ST_CHECK = 4'b0100,
		ST_STORE = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		req_ready   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = sts.range_empty ? ST_STORE : ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.step = 1'b1;
				if (sts.last_term) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				if (!sts.is_max || sts.at_end) begin
					state_d = ST_STORE;
				end else begin
					cmd.advance = 1'b1;
					state_d     = ST_EVAL;
				end
			end
			ST_STORE: begin
				if (sts.out_free) begin
					cmd.store = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

>>> hdl/pep_dp.sv
// Datapath: Horner multiply-add, x stepping, running maximum and result register.
module pep_dp #(
	parameter int MAX_TERMS = 7
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [pep_pkg::TERM_W-1:0]            term_count,
	input  pep_pkg::coeff_arr_t                   coeff,
	input  logic                                  in_req_type,
	input  logic signed [pep_pkg::X_W-1:0]        in_x_low,
	input  logic signed [pep_pkg::X_W-1:0]        in_x_high,
	input  pep_pkg::pep_cmd_t                     cmd,
	output pep_pkg::pep_sts_t                     sts,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [pep_pkg::VALUE_W-1:0]    out_value
);

	logic signed [pep_pkg::X_W-1:0]         x_q;
	logic signed [pep_pkg::X_W-1:0]         end_q;
	logic                                   max_q;
	logic [pep_pkg::TERM_W-1:0]             j_q;
	logic signed [pep_pkg::VALUE_W-1:0]     acc_q;
	logic signed [pep_pkg::VALUE_W-1:0]     best_q;
	logic signed [pep_pkg::VALUE_W-1:0]     out_value_q;
	logic                                   out_valid_q;

	logic [pep_pkg::TERM_W-1:0]             t_used;
	logic [pep_pkg::TERM_W-1:0]             t_last;
	logic signed [pep_pkg::VALUE_W-1:0]     x_ext;
	logic signed [pep_pkg::VALUE_W-1:0]     prod;
	pep_pkg::coeff_t                        c_sel;
	logic signed [pep_pkg::VALUE_W-1:0]     acc_d;

	always_comb begin
		t_used = term_count;
		if (t_used == 3'd0) begin
			t_used = 3'd1;
		end
		if (t_used > pep_pkg::TERM_W'(MAX_TERMS)) begin
			t_used = pep_pkg::TERM_W'(MAX_TERMS);
		end
		t_last = t_used - 3'd1;
	end

	assign c_sel = $signed(coeff[j_q]);
	assign x_ext = $signed({{(pep_pkg::VALUE_W-pep_pkg::X_W){x_q[pep_pkg::X_W-1]}}, x_q});
	assign prod  = acc_q * x_ext;
	assign acc_d = prod
		+ {{(pep_pkg::VALUE_W-pep_pkg::COEFF_W){c_sel[pep_pkg::COEFF_W-1]}}, c_sel};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q    <= in_x_low;
			end_q  <= in_x_high;
			max_q  <= in_req_type;
			acc_q  <= '0;
			best_q <= '0;
			j_q    <= t_last;
		end else if (cmd.step) begin
			acc_q <= acc_d;
			j_q   <= j_q - 3'd1;
		end else if (cmd.check) begin
			if (max_q && (acc_q >= best_q)) begin
				best_q <= acc_q;
			end
			if (cmd.advance) begin
				x_q   <= x_q + 8'sd1;
				acc_q <= '0;
				j_q   <= t_last;
			end
		end
		if (cmd.store) begin
			out_value_q <= max_q ? best_q : acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.store) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.last_term   = (j_q == 3'd0);
	assign sts.range_empty = in_req_type && (in_x_low > in_x_high);
	assign sts.at_end      = (x_q == end_q);
	assign sts.is_max      = max_q;
	assign sts.out_free    = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;

endmodule

>>> hdl/polynomial_eval_range_max.sv
// Top level: polynomial evaluator with range maximum.
//
//  channel  dir  handshake        payload
//  req      in   valid / ready    req_type, x_low, x_high
//  res      out  valid / ready    value, saturated
//  apb      in   psel / penable   paddr, pwdata, prdata (pready tied high)
//
// One Horner multiply-add per cycle; each point ends with a check step.
// An empty range skips evaluation and goes straight to the store step.
// One request at a time; a finished result waits in the output register
// while the next request is taken, and a result not yet taken holds the
// next one back. Reset restores term count 1, coefficients 0.
module polynomial_eval_range_max #(
	parameter int MAX_TERMS = 7
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [pep_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [pep_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [pep_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready,
	pep_req_if.sink                            req,
	pep_res_if.source                          res
);

	logic [pep_pkg::TERM_W-1:0]  term_count;
	pep_pkg::coeff_arr_t         coeff;
	pep_pkg::pep_cmd_t           cmd;
	pep_pkg::pep_sts_t           sts;

	pep_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.term_count (term_count),
		.coeff      (coeff)
	);

	pep_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	pep_dp #(
		.MAX_TERMS (MAX_TERMS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.term_count  (term_count),
		.coeff       (coeff),
		.in_req_type (req.req_type),
		.in_x_low    (req.x_low),
		.in_x_high   (req.x_high),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (res.valid),
		.out_ready   (res.ready),
		.out_value   (res.value)
	);

	// values stay below 2^58 in magnitude, so nothing is ever clipped
	assign res.saturated = 1'b0;

endmodule
